/* hw/rtl/vln_pkg.sv */
// Shared types and constants for the vector L2 norm block.
package vln_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int SCALE_W    = 24;
    localparam int ZERO_W     = 8;
    localparam int SUM_W      = 56;
    localparam int NORM_W     = 48;
    localparam int SQ_W       = 32;
    localparam int MAG_W      = 16;

    // Square root unit: radicand holds sum << 32 at most, one bit pair per step
    localparam int RAD_W      = SUM_W + 32;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int ROOT_ITERS = ROOT_W;
    localparam int ITER_W     = $clog2(ROOT_ITERS);

    // Scale multiply split (root = rh:rl, rl is the Q.16 fraction)
    localparam int FRAC_W     = 16;
    localparam int RH_W       = ROOT_W - FRAC_W;
    localparam int PHI_W      = SCALE_W + RH_W;
    localparam int PLO_W      = SCALE_W + FRAC_W;
    localparam int NFULL_W    = PHI_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_ZERO   = 2'd2;

    // Element kinds
    localparam logic KIND_FIXED = 1'b0;
    localparam logic KIND_QUANT = 1'b1;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h010000;

    // Controller states
    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_LOAD,
        ST_ROOT,
        ST_MULT,
        ST_FINISH
    } vln_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic sq_load;
        logic root_load;
        logic root_step;
        logic mult_en;
        logic finish;
    } vln_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } vln_status_t;

endpackage

/* hw/rtl/vln_if.sv */
// Stream channel interfaces for the vector L2 norm block.
interface vln_in_if
    import vln_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface vln_out_if
    import vln_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NORM_W-1:0] norm_value;
    logic              saturated;

    modport source (output valid, output norm_value, output saturated, input ready);
    modport sink   (input valid, input norm_value, input saturated, output ready);
endinterface

/* hw/rtl/vln_ctrl.sv */
// Controller state machine for the vector L2 norm block.
module vln_ctrl
    import vln_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  vln_status_t status,
    output vln_cmd_t    cmd
);

    vln_state_t          state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                in_fire;
    logic                root_done;

    assign in_fire   = in_valid && (state_reg == ST_ACCUM);
    assign root_done = (iter_reg == ITER_W'(ROOT_ITERS - 1));

    // State and iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (in_fire && in_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                iter_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                iter_next = iter_reg + 1'b1;
                if (root_done)
                    state_next = ST_MULT;
            end
            ST_MULT:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_ACCUM;
            end
            default:
                state_next = ST_ACCUM;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_ACCUM:
            begin
                in_ready    = 1'b1;
                cmd.sq_load = in_valid;
            end
            ST_DRAIN:
                cmd = '0;
            ST_LOAD:
                cmd.root_load = 1'b1;
            ST_ROOT:
                cmd.root_step = 1'b1;
            ST_MULT:
                cmd.mult_en = 1'b1;
            ST_FINISH:
                cmd.finish = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/vln_dpath.sv */
// Datapath: square, saturating accumulate, bit-pair square root, scaling, output register.
module vln_dpath
    import vln_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  vln_cmd_t                   cmd,
    output vln_status_t                status,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [NORM_W-1:0]          norm_value,
    output logic                       saturated
);

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

    // Configuration registers
    logic               kind_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [ZERO_W-1:0]  zero_reg;

    // Square stage
    logic [SAMPLE_W:0]  fix_abs;
    logic [ZERO_W:0]    q_diff;
    logic [ZERO_W:0]    q_abs;
    logic [MAG_W-1:0]   mag;
    logic [SQ_W-1:0]    sq_reg;
    logic               sq_vld_reg;

    // Accumulator
    logic [SUM_W-1:0]   sum_reg;
    logic               ovf_reg;
    logic [SUM_W:0]     sum_add;

    // Square root unit
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic               kind_l_reg;
    logic               sat_l_reg;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   rem_sub;
    logic               take;

    // Scaling
    logic [PHI_W-1:0]   p_hi_reg;
    logic [PLO_W-1:0]   p_lo_reg;
    logic [NFULL_W-1:0] quant_norm;
    logic [NFULL_W-1:0] norm_full;
    logic               norm_over;

    // Output register
    logic               out_vld_reg;
    logic [NORM_W-1:0]  norm_reg;
    logic               sat_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_FIXED;
            scale_reg <= SCALE_RESET;
            zero_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ELEMENT_KIND: kind_reg  <= cfg_data[0];
                CFG_QUANT_SCALE:  scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_QUANT_ZERO:   zero_reg  <= cfg_data[ZERO_W-1:0];
                default:          kind_reg  <= kind_reg;
            endcase
        end
    end

    // Magnitude of the element under the current mode
    always_comb
    begin
        fix_abs = sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample})
                                     : {1'b0, sample};
        q_diff  = {sample[ZERO_W-1], sample[ZERO_W-1:0]} - {zero_reg[ZERO_W-1], zero_reg};
        q_abs   = q_diff[ZERO_W] ? ((ZERO_W+1)'(0) - q_diff) : q_diff;
        mag     = (kind_reg == KIND_QUANT) ? MAG_W'(q_abs[ZERO_W-1:0]) : fix_abs[MAG_W-1:0];
    end

    // Square register
    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= 1'b0;
        else
            sq_vld_reg <= cmd.sq_load;
    end

    // Saturating accumulate; cleared when the root unit takes the sum
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.root_load)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (sq_vld_reg)
        begin
            if (sum_add[SUM_W])
            begin
                sum_reg <= SUM_MAX;
                ovf_reg <= 1'b1;
            end
            else
                sum_reg <= sum_add[SUM_W-1:0];
        end
    end

    // One root bit per step
    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        take    = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_load)
        begin
            rad_reg    <= (kind_reg == KIND_QUANT) ? {sum_reg, 32'd0}
                                                   : {16'd0, sum_reg, 16'd0};
            rem_reg    <= '0;
            root_reg   <= '0;
            kind_l_reg <= kind_reg;
            sat_l_reg  <= ovf_reg;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    // Scale multiply, split into integer and fraction halves of the root
    always_ff @(posedge clk)
    begin
        if (cmd.mult_en)
        begin
            p_hi_reg <= PHI_W'(scale_reg) * PHI_W'(root_reg[ROOT_W-1:FRAC_W]);
            p_lo_reg <= PLO_W'(scale_reg) * PLO_W'(root_reg[FRAC_W-1:0]);
        end
    end

    // Norm selection and clamp
    always_comb
    begin
        quant_norm = NFULL_W'(p_hi_reg) + NFULL_W'(p_lo_reg[PLO_W-1:FRAC_W]);
        norm_full  = (kind_l_reg == KIND_QUANT) ? quant_norm : NFULL_W'(root_reg);
        norm_over  = |norm_full[NFULL_W-1:NORM_W];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.finish)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            norm_reg <= norm_over ? NORM_MAX : norm_full[NORM_W-1:0];
            sat_reg  <= sat_l_reg | norm_over;
        end
    end

    assign status.out_free = !out_vld_reg || out_ready;
    assign out_valid       = out_vld_reg;
    assign norm_value      = norm_reg;
    assign saturated       = sat_reg;

endmodule

/* hw/rtl/vector_l2_norm.sv */
// Top level of the vector L2 norm block.
//
//  channel  | dir | beat payload                   | handshake
//  in_ch    | in  | sample (s16), last             | valid / ready
//  out_ch   | out | norm_value (u48, Q40.8 fixed / Q32.16 quant), sat. | valid / ready
//  cfg      | in  | cfg_index, cfg_data            | cfg_we, no back-pressure
//
// An element that is not last does not hold off input: its square is registered and
// added into the 56-bit sum on the following cycle.
// A last element holds off input through drain, load, 44 steps of the
// bit-pair square root unit, one scale multiply, then the output register.
// A result waiting in the output register stalls only the next vector's end.
// Reset clears the sum, the overflow mark, the output valid and loads the
// register defaults (fixed mode, scale 1.0, zero point 0).
module vector_l2_norm
    import vln_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    vln_in_if.sink                in_ch,
    vln_out_if.source             out_ch
);

    vln_cmd_t    cmd;
    vln_status_t status;

    // Sequencer
    vln_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic
    vln_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (in_ch.sample),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .norm_value (out_ch.norm_value),
        .saturated  (out_ch.saturated)
    );

endmodule

/* hw/rtl/vln_checker.sv */
// Port-level checks for the vector L2 norm block, bound to the top level.
module vln_checker
    import vln_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_last,
    input logic              out_valid,
    input logic              out_ready,
    input logic [NORM_W-1:0] norm_value
);

    // End of vector blocks input while the norm is worked out
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready ##1 !in_ready)
        else $error("input taken too soon after last beat");

    // A new result only appears after input was held off
    a_result_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while input was open");

    // A last beat is never followed at once by a new result
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !out_valid || $past(out_valid))
        else $error("result appeared one cycle after last beat");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(norm_value))
        else $error("stalled result changed");

endmodule

bind vector_l2_norm vln_checker u_vln_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_last    (in_ch.last),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .norm_value (out_ch.norm_value)
);

/* tb/vln_norm_checker.sv */
// Watches the stream channels and the register port, predicts each norm and compares it.
module vln_norm_checker
    import vln_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    vln_in_if                     in_ch,
    vln_out_if                    out_ch,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [NORM_W-1:0] NORM_MAX = '1;

    typedef struct packed {
        logic [NORM_W-1:0] norm_value;
        logic              saturated;
    } norm_result_t;

    // Shadow registers and running state
    logic                     kind;
    logic [SCALE_W-1:0]       scale;
    logic signed [ZERO_W-1:0] zero;
    logic [SUM_W-1:0]         sum_sq;
    logic                     overflow;
    norm_result_t             norms_due[$];

    // Truncated square root, two radicand bits per step
    function automatic logic [63:0] isqrt(input logic [127:0] rad);
        logic [127:0] root;
        logic [127:0] rem;
        logic [127:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem   = (rem << 2) | 128'(rad[2*i +: 2]);
            trial = (root << 2) | 128'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 128'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        return root[63:0];
    endfunction

    // Square of one element under the mode in force now
    function automatic logic [31:0] element_square(input logic [SAMPLE_W-1:0] raw);
        logic signed [17:0] d;
        logic [17:0]        mag;
        if (kind == KIND_FIXED)
            d = $signed(raw);
        else
            d = $signed(raw[7:0]) - zero;  // only the low byte counts
        mag = (d < 0) ? 18'(-d) : 18'(d);
        return 32'(mag) * 32'(mag);
    endfunction

    // Norm of the finished vector, clamped to the output range
    function automatic norm_result_t vector_norm();
        norm_result_t res;
        logic [63:0]  root;
        logic [63:0]  norm;
        res.saturated = overflow;
        if (kind == KIND_FIXED)
        begin
            norm = isqrt(128'(sum_sq) << 16);
        end
        else
        begin
            root = isqrt(128'(sum_sq) << 32);
            norm = 64'(scale) * (root >> 16) + ((64'(scale) * 64'(root[15:0])) >> 16);
        end
        if (norm > 64'(NORM_MAX))
        begin
            norm          = 64'(NORM_MAX);
            res.saturated = 1'b1;
        end
        res.norm_value = norm[NORM_W-1:0];
        return res;
    endfunction

    // Sample every channel at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        norm_result_t     got;
        norm_result_t     want;
        logic [SUM_W:0]   total;
        if (!rst_n)
        begin
            kind     = KIND_FIXED;
            scale    = SCALE_RESET;
            zero     = '0;
            sum_sq   = '0;
            overflow = 1'b0;
            norms_due.delete();
            errors   = 0;
            pending  = 0;
        end
        else
        begin
            // result beat first: it can never belong to a same-cycle input beat
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.norm_value, out_ch.saturated};
                if (norms_due.size() == 0)
                begin
                    $error("unexpected result beat: norm_value %0d saturated %0b",
                           got.norm_value, got.saturated);
                    errors++;
                end
                else
                begin
                    want = norms_due.pop_front();
                    if (got.norm_value !== want.norm_value)
                    begin
                        $error("norm_value: expected %0d, got %0d",
                               want.norm_value, got.norm_value);
                        errors++;
                    end
                    if (got.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, got.saturated);
                        errors++;
                    end
                end
            end

            // element beat: saturating accumulate, norm on the last one
            if (in_ch.valid && in_ch.ready)
            begin
                total = {1'b0, sum_sq} + 57'(element_square(in_ch.sample));
                if (total > {1'b0, SUM_MAX})
                begin
                    sum_sq   = SUM_MAX;
                    overflow = 1'b1;
                end
                else
                begin
                    sum_sq = total[SUM_W-1:0];
                end
                if (in_ch.last)
                begin
                    norms_due.push_back(vector_norm());
                    sum_sq   = '0;
                    overflow = 1'b0;
                end
            end

            // register writes; spare index is ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ELEMENT_KIND: kind  = cfg_data[0];
                    CFG_QUANT_SCALE:  scale = cfg_data[SCALE_W-1:0];
                    CFG_QUANT_ZERO:   zero  = cfg_data[ZERO_W-1:0];
                    default:          ;
                endcase
            end

            pending = norms_due.size();
        end
    end

endmodule

/* tb/vector_l2_norm_tb.sv */
// Stimulus and verdict for the vector L2 norm block.
module vector_l2_norm_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vln_pkg::*;

    localparam int ITEM_TARGET  = 1450;
    localparam int PHASE_ITEMS  = 180;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 300;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE = 2'd3;
    localparam logic signed [ZERO_W-1:0] ZERO_MIN = 8'sh80;
    localparam logic signed [ZERO_W-1:0] ZERO_MAX = 8'sh7F;
    localparam logic [SCALE_W-1:0]       SCALE_MAX = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    items_sent;
    bit                    idling;
    bit                    hold_request;
    logic                  mode_quant;

    vln_in_if  in_ch();
    vln_out_if out_ch();

    vector_l2_norm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    vln_norm_checker norm_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .errors    (errors),
        .pending   (pending)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #4_000_000;
        $display("[vector_l2_norm] ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int short_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Element value suited to the current mode, with some out-of-range noise
    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [7:0] b;
        int         r;
        r = $urandom_range(0, 9);
        b = 8'($urandom);
        if (!mode_quant)
        begin
            if (r == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            return 16'($urandom);
        end
        if (r < 7)
            return {{8{b[7]}}, b};
        else if (r < 9)
            return 16'($urandom);
        else
            return ($urandom_range(0, 1) != 0) ? 16'hFF80 : 16'h007F;
    endfunction

    function automatic int vector_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 6);
        else if (r < 97)
            return $urandom_range(7, 30);
        else
            return $urandom_range(100, 250);
    endfunction

    // One element beat; returns at the falling edge after acceptance
    task automatic send_beat(input logic [SAMPLE_W-1:0] s, input logic l);
        int gap;
        gap = (idling && $urandom_range(0, 2) == 0) ? short_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.sample = s;
        in_ch.last   = l;
        in_ch.valid  = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // closed = 0 leaves the vector open across the next settings change
    task automatic send_vector(input int len, input bit closed);
        for (int k = 0; k < len; k++)
            send_beat(random_sample(), closed && (k == len - 1));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Unused upper data bits carry noise
    task automatic set_regs(input logic kind, input logic [SCALE_W-1:0] scale,
                            input logic signed [ZERO_W-1:0] zero);
        write_reg(CFG_ELEMENT_KIND, {23'($urandom), kind});
        write_reg(CFG_QUANT_SCALE, scale);
        write_reg(CFG_QUANT_ZERO, {16'($urandom), zero});
        mode_quant = kind;
    endtask

    // Block idle: nothing owed, then let any element in flight settle
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
                out_ch.ready = 1'b1;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat (short_gap()) @(negedge clk);
                out_ch.ready = 1'b1;
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Element side
    initial
    begin : stimulus
        int phase;
        int phase_end;
        bit held;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ELEMENT_KIND;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        in_ch.last   = 1'b0;
        idling       = 1'b0;
        hold_request = 1'b0;
        mode_quant   = KIND_FIXED;
        items_sent   = 0;
        phase        = 0;
        held         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fixed mode from reset: zero, both extremes, a short vector
        send_beat(16'h0000, 1'b1);
        send_beat(16'h8000, 1'b1);
        send_beat(16'h7FFF, 1'b1);
        send_beat(16'h0100, 1'b0);
        send_beat(16'h0100, 1'b0);
        send_beat(16'hFF00, 1'b1);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0001, 1'b1);

        // switch to quantized mode part way through a vector
        send_beat(16'h0300, 1'b0);
        wait_idle();
        set_regs(KIND_QUANT, SCALE_MAX, ZERO_MAX);
        send_beat(16'h7F80, 1'b1);  // upper byte ignored, value -128
        send_beat(16'h007F, 1'b1);
        send_beat(16'hFF80, 1'b0);
        send_beat(16'h0080, 1'b1);

        // zero scale, lowest zero point
        wait_idle();
        set_regs(KIND_QUANT, '0, ZERO_MIN);
        send_beat(16'h007F, 1'b1);
        send_beat(16'h0000, 1'b1);

        // spare register index must change nothing
        wait_idle();
        write_reg(CFG_SPARE, 24'($urandom));
        set_regs(KIND_QUANT, SCALE_RESET, '0);
        send_beat(16'h0005, 1'b0);
        send_beat(16'hFFFB, 1'b1);

        // back to fixed mode inside a vector
        send_beat(16'h0040, 1'b0);
        wait_idle();
        set_regs(KIND_FIXED, SCALE_RESET, '0);
        send_beat(16'h4000, 1'b1);

        // random phases, each under its own settings
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            case (phase)
                0:       set_regs(KIND_FIXED, SCALE_MAX, ZERO_MIN);
                1:       set_regs(KIND_QUANT, SCALE_MAX, ZERO_MIN);
                2:       set_regs(KIND_QUANT, '0, ZERO_MAX);
                3:       set_regs(KIND_QUANT, SCALE_RESET, 8'($urandom));
                default: set_regs(logic'($urandom_range(0, 1)),
                                  ($urandom_range(0, 3) == 0) ?
                                      24'($urandom_range(0, 65536)) : 24'($urandom),
                                  8'($urandom));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, 24'($urandom));
            idling    = (phase % 3 != 1);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < ITEM_TARGET)
            begin
                if (phase == 3 && !held)
                begin
                    // result side stalls long: output register fills, input backs up
                    held         = 1'b1;
                    hold_request = 1'b1;
                    repeat (8) send_vector($urandom_range(1, 4), 1'b1);
                end
                else
                begin
                    send_vector(vector_len(), 1'b1);
                end
            end
            // sometimes carry a part vector over the settings change
            if ($urandom_range(0, 2) == 0)
                send_vector($urandom_range(1, 5), 1'b0);
            phase++;
        end

        wait_idle();
        if (errors == 0)
            $display("[vector_l2_norm] OK");
        else
            $display("[vector_l2_norm] ERROR");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/vln_pkg.sv
hw/rtl/vln_if.sv
hw/rtl/vln_ctrl.sv
hw/rtl/vln_dpath.sv
hw/rtl/vector_l2_norm.sv
hw/rtl/vln_checker.sv
tb/vln_norm_checker.sv
tb/vector_l2_norm_tb.sv
